### sv/untal_pkg.sv
// Package with the shared constants, codes and control structs of the name table allocator.
package untal_pkg;

    localparam int ENTRIES    = 512;
    localparam int NAME_BYTES = 32;
    localparam int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BW         = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int ROW_W      = NAME_BYTES * 8;
    localparam int PEND_DEPTH = 31;
    localparam int KEEP_MAX   = ((NAME_BYTES - 1) < PEND_DEPTH) ? (NAME_BYTES - 1) : PEND_DEPTH;

    localparam logic [15:0] ID_BASE    = 16'h7800;
    localparam logic [4:0]  CUSTOM_TAG = 5'd15;
    localparam logic [4:0]  LAST_BYTE  = 5'd31;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_IN_USE = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NOT_ID = 2'd3;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_issue;
        logic clr_write;
        logic emit_alloc;
        logic emit_del;
        logic rd_issue;
        logic emit_byte;
    } t_cmd;

    typedef struct packed {
        logic addr_last;
        logic out_free;
        logic byte_last;
    } t_sts;

endpackage

### sv/untal_ctrl.sv
// Controller state machine that sequences clearing, scans, deletes and reads.
module untal_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_kind,
    input  logic           i_name_end,
    input  untal_pkg::t_sts i_sts,
    output untal_pkg::t_cmd o_cmd,
    output logic           o_stall
);
    import untal_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_DEL    = 3'd5;
    localparam logic [2:0] S_RDREQ  = 3'd6;
    localparam logic [2:0] S_STREAM = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.addr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_kind == KIND_ALLOC) begin
                        if (i_name_end) begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_SCAN;
                        end
                    end else if (i_kind == KIND_DELETE) begin
                        n_state = S_DEL;
                    end else if (i_kind == KIND_READ) begin
                        n_state = S_RDREQ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.addr_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_alloc = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DEL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_del = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RDREQ: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_STREAM;
            end
            S_STREAM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_sts.byte_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/untal_dp.sv
// Datapath with the name store, pending name, scan flags and result register.
module untal_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  untal_pkg::t_cmd i_cmd,
    output untal_pkg::t_sts o_sts,
    input  logic [1:0]      i_kind,
    input  logic [7:0]      i_name_char,
    input  logic            i_check_duplicate,
    input  logic [7:0]      i_skip_value,
    input  logic [15:0]     i_name_id,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [15:0]     o_new_id,
    output logic [7:0]      o_out_char,
    output logic            o_last_result
);
    import untal_pkg::*;

    logic [ROW_W-1:0] mem [ENTRIES];
    logic [ROW_W-1:0] r_rd_row;

    logic [7:0]    r_pend [PEND_DEPTH];
    logic [4:0]    r_plen;
    logic          r_dup;
    logic [7:0]    r_skip;
    logic [15:0]   r_id;
    logic [AW-1:0] r_addr;
    logic          r_chk;
    logic [AW-1:0] r_chk_idx;
    logic          r_found;
    logic [AW-1:0] r_free_idx;
    logic          r_hit;
    logic [4:0]    r_k;

    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [15:0]   r_new_id;
    logic [7:0]    r_char;
    logic          r_last;

    logic [ROW_W-1:0] w_new_row;
    logic             w_idx_ok;
    logic [AW-1:0]    w_idx;
    logic             w_custom;
    logic [7:0]       w_byte;
    logic [5:0]       w_k6;
    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [ROW_W-1:0] w_wd;
    logic [AW-1:0]    w_ra;
    logic [1:0]       w_alloc_st;

    always_comb begin
        logic ended;
        logic [7:0] b;
        ended = 1'b0;
        w_new_row = '0;
        for (int p = 0; p < NAME_BYTES; p++) begin
            b = 8'd0;
            if (p < NAME_BYTES - 1 && p < PEND_DEPTH && !ended) begin
                if (5'(p) < r_plen) b = r_pend[p];
            end
            if (b == 8'd0) ended = 1'b1;
            w_new_row[p*8 +: 8] = b;
        end
    end

    assign w_idx    = r_id[AW-1:0];
    assign w_idx_ok = ({1'b0, r_id[8:0]} < 10'(ENTRIES));
    assign w_custom = (r_id[15:11] == CUSTOM_TAG);
    assign w_k6     = {1'b0, r_k};

    always_comb begin
        w_byte = 8'd0;
        if (w_idx_ok && w_k6 < 6'(NAME_BYTES)) w_byte = r_rd_row[w_k6[BW-1:0]*8 +: 8];
    end

    assign w_alloc_st = r_hit ? ST_IN_USE : (r_found ? ST_OK : ST_FULL);

    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = '0;
        priority if (i_cmd.clr_write) begin
            w_we = 1'b1;
        end else if (i_cmd.emit_alloc) begin
            w_we = (w_alloc_st == ST_OK);
            w_wa = r_free_idx;
            w_wd = w_new_row;
        end else if (i_cmd.emit_del) begin
            w_we = w_custom && w_idx_ok;
            w_wa = w_idx;
        end else begin
            w_we = 1'b0;
        end
    end

    assign w_ra = i_cmd.scan_issue ? r_addr : w_idx;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        if (i_cmd.scan_issue || i_cmd.rd_issue) r_rd_row <= mem[w_ra];
    end

    assign o_sts.addr_last = (r_addr == AW'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || !i_stall;
    assign o_sts.byte_last = (w_byte == 8'd0) || (r_k == LAST_BYTE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dup  <= i_check_duplicate;
            r_skip <= i_skip_value;
            r_id   <= i_name_id;
            if (i_kind == KIND_ALLOC && r_plen < 5'(KEEP_MAX)) r_pend[r_plen] <= i_name_char;
        end
        r_chk_idx <= r_addr;
        if (r_chk) begin
            if (r_rd_row[7:0] == 8'd0) begin
                if (!r_found) r_free_idx <= r_chk_idx;
            end
        end
        if (i_cmd.rd_issue) r_k <= 5'd0;
        else if (i_cmd.emit_byte) r_k <= r_k + 5'd1;
        if (i_cmd.emit_alloc) begin
            r_status <= w_alloc_st;
            r_new_id <= (w_alloc_st == ST_OK)
                        ? (16'(r_free_idx) | ID_BASE | {r_skip, 8'd0}) : 16'd0;
            r_char   <= 8'd0;
            r_last   <= 1'b1;
        end else if (i_cmd.emit_del) begin
            r_status <= w_custom ? ST_OK : ST_NOT_ID;
            r_new_id <= 16'd0;
            r_char   <= 8'd0;
            r_last   <= 1'b1;
        end else if (i_cmd.emit_byte) begin
            r_status <= ST_OK;
            r_new_id <= 16'd0;
            r_char   <= w_byte;
            r_last   <= o_sts.byte_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= 5'd0;
            r_addr      <= '0;
            r_chk       <= 1'b0;
            r_found     <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan_issue;
            if (i_cmd.accept && i_kind == KIND_ALLOC && r_plen < 5'(KEEP_MAX)) begin
                r_plen <= r_plen + 5'd1;
            end else if (i_cmd.emit_alloc) begin
                r_plen <= 5'd0;
            end
            if (i_cmd.scan_start) begin
                r_addr  <= '0;
                r_found <= 1'b0;
                r_hit   <= 1'b0;
            end else begin
                if (i_cmd.scan_issue || i_cmd.clr_write) begin
                    r_addr <= o_sts.addr_last ? '0 : r_addr + AW'(1);
                end
                if (r_chk) begin
                    if (r_rd_row[7:0] == 8'd0) begin
                        r_found <= 1'b1;
                    end else if (r_dup && r_rd_row == w_new_row) begin
                        r_hit <= 1'b1;
                    end
                end
            end
            if (i_cmd.emit_alloc || i_cmd.emit_del || i_cmd.emit_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_new_id      = r_new_id;
    assign o_out_char    = r_char;
    assign o_last_result = r_last;

endmodule

### sv/unique_name_table_allocator_unit.sv
// Top level of the name table allocator, joining the controller and the datapath.
//
//  channel  | valid    | stall    | payload
//  input    | i_valid  | o_stall  | i_kind i_name_char i_name_end i_check_duplicate
//           |          |          | i_skip_value i_name_id
//  output   | o_valid  | i_stall  | o_status o_new_id o_out_char o_last_result
//
// A name byte that is not last is taken while the block stays idle; the last byte scans every entry, one
// stored row per cycle through the store's read port, before the result is given.
// A delete waits for a free output, and a read fetches the row and then sends it byte by byte.
// After reset a clearing pass writes every row, one row per cycle, with the
// input stalled. A stalled output holds the result and the machine waits for it.
module unique_name_table_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_name_char,
    input  logic        i_name_end,
    input  logic        i_check_duplicate,
    input  logic [7:0]  i_skip_value,
    input  logic [15:0] i_name_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_new_id,
    output logic [7:0]  o_out_char,
    output logic        o_last_result
);
    import untal_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    untal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_kind     (i_kind),
        .i_name_end (i_name_end),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_stall    (o_stall)
    );

    untal_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_kind            (i_kind),
        .i_name_char       (i_name_char),
        .i_check_duplicate (i_check_duplicate),
        .i_skip_value      (i_skip_value),
        .i_name_id         (i_name_id),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_new_id          (o_new_id),
        .o_out_char        (o_out_char),
        .o_last_result     (o_last_result)
    );

endmodule

### tb/untal_checker.sv
// Checker that predicts the name table allocator and compares every output transfer.
module untal_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_name_char,
    input  logic        i_name_end,
    input  logic        i_check_duplicate,
    input  logic [7:0]  i_skip_value,
    input  logic [15:0] i_name_id,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_new_id,
    input  logic [7:0]  i_out_char,
    input  logic        i_last_result,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import untal_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_id;
        logic [7:0]  ch;
        logic        last;
    } t_answer;

    logic [7:0] name_table [ENTRIES*NAME_BYTES];
    logic [7:0] name_buf [PEND_DEPTH];
    int         name_len;
    t_answer    answers_due [$];
    int         fails;

    assign o_fail_count = fails;
    assign o_pending    = answers_due.size();

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic push_answer(input logic [1:0] st, input logic [15:0] id,
                               input logic [7:0] ch, input logic last);
        t_answer a;
        a.status = st;
        a.new_id = id;
        a.ch     = ch;
        a.last   = last;
        answers_due.push_back(a);
    endtask

    function automatic logic [7:0] held_byte(input int p);
        return (p < name_len && p < PEND_DEPTH) ? name_buf[p] : 8'h00;
    endfunction

    function automatic bit name_matches(input int base);
        logic [7:0] b;
        for (int p = 0; p + 1 < NAME_BYTES; p++) begin
            b = name_table[base + p];
            if (b != held_byte(p)) return 1'b0;
            if (b == 8'h00) return 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic predict_item(input logic [1:0] kind, input logic [7:0] ch,
                                input logic last_byte, input logic dup,
                                input logic [7:0] skip, input logic [15:0] id);
        int   free_idx;
        bit   have_free;
        bit   taken;
        bit   ended;
        int   base;
        int   row;
        logic [7:0] b;
        free_idx  = 0;
        have_free = 0;
        taken     = 0;
        row       = int'(id & 16'h01FF);
        if (kind == KIND_ALLOC) begin
            if (name_len < KEEP_MAX) begin
                name_buf[name_len] = ch;
                name_len++;
            end
            if (!last_byte) return;
            for (int e = 0; e < ENTRIES; e++) begin
                base = e * NAME_BYTES;
                if (name_table[base] == 8'h00) begin
                    if (!have_free) begin
                        have_free = 1;
                        free_idx  = e;
                    end
                end else if (dup && name_matches(base)) begin
                    taken = 1;
                    break;
                end
            end
            if (taken) begin
                push_answer(ST_IN_USE, 16'h0, 8'h0, 1'b1);
            end else if (!have_free) begin
                push_answer(ST_FULL, 16'h0, 8'h0, 1'b1);
            end else begin
                base  = free_idx * NAME_BYTES;
                ended = 0;
                for (int p = 0; p < NAME_BYTES; p++) begin
                    b = (p + 1 < NAME_BYTES && !ended) ? held_byte(p) : 8'h00;
                    if (b == 8'h00) ended = 1;
                    name_table[base + p] = b;
                end
                push_answer(ST_OK, 16'(free_idx) | ID_BASE | {skip, 8'h00}, 8'h0, 1'b1);
            end
            name_len = 0;
        end else if (kind == KIND_DELETE) begin
            if (id[15:11] != CUSTOM_TAG) begin
                push_answer(ST_NOT_ID, 16'h0, 8'h0, 1'b1);
            end else begin
                if (row < ENTRIES)
                    for (int p = 0; p < NAME_BYTES; p++) name_table[row*NAME_BYTES + p] = 8'h00;
                push_answer(ST_OK, 16'h0, 8'h0, 1'b1);
            end
        end else if (kind == KIND_READ) begin
            if (row >= ENTRIES) begin
                push_answer(ST_OK, 16'h0, 8'h0, 1'b1);
            end else begin
                for (int k = 0; k < 32; k++) begin
                    b = (k < NAME_BYTES) ? name_table[row*NAME_BYTES + k] : 8'h00;
                    push_answer(ST_OK, 16'h0, b, (b == 8'h00) || (k == 31));
                    if (b == 8'h00 || k == 31) break;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES*NAME_BYTES; i++) name_table[i] = 8'h00;
            name_len = 0;
            answers_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    report("result with nothing expected", i_status, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status) report("status", i_status, want.status);
                    if (i_new_id !== want.new_id) report("new_id", i_new_id, want.new_id);
                    if (i_out_char !== want.ch) report("out_char", i_out_char, want.ch);
                    if (i_last_result !== want.last)
                        report("last_result", i_last_result, want.last);
                end
            end
            if (i_valid && !i_stall_in)
                predict_item(i_kind, i_name_char, i_name_end, i_check_duplicate,
                             i_skip_value, i_name_id);
        end
    end

    initial begin
        fails    = 0;
        name_len = 0;
    end
endmodule

### tb/testbench.sv
// Top of the name table allocator testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
    import untal_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [7:0]  i_name_char;
    logic        i_name_end;
    logic        i_check_duplicate;
    logic [7:0]  i_skip_value;
    logic [15:0] i_name_id;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [15:0] o_new_id;
    logic [7:0]  o_out_char;
    logic        o_last_result;

    int fail_count;
    int answers_pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int quiet_cycles;
    int items_sent;
    int results_seen;

    unique_name_table_allocator_unit dut (.*);

    untal_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_stall_in        (o_stall),
        .i_kind            (i_kind),
        .i_name_char       (i_name_char),
        .i_name_end        (i_name_end),
        .i_check_duplicate (i_check_duplicate),
        .i_skip_value      (i_skip_value),
        .i_name_id         (i_name_id),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_status          (o_status),
        .i_new_id          (o_new_id),
        .i_out_char        (o_out_char),
        .i_last_result     (o_last_result),
        .o_fail_count      (fail_count),
        .o_pending         (answers_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The receiver stalls at random, or for a whole hold-off stretch when one is requested.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_stall = 1'b1;
            hold_off_cycles--;
        end else begin
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (o_valid && !i_stall) results_seen++;
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                             input logic last_byte, input logic dup,
                             input logic [7:0] skip, input logic [15:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_kind            = kind;
        i_name_char       = ch;
        i_name_end        = last_byte;
        i_check_duplicate = dup;
        i_skip_value      = skip;
        i_name_id         = id;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_name(input int len, input logic dup, input int top_char);
        logic [7:0] skip;
        skip = 8'($urandom_range(255));
        for (int i = 0; i < len; i++)
            send_item(KIND_ALLOC, 8'($urandom_range(1, top_char)), i == len - 1, dup, skip,
                      16'($urandom));
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (answers_pending != 0) @(negedge i_clk);
        repeat (ENTRIES + 8) @(negedge i_clk);
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            send_name(($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 4),
                      1'($urandom), ($urandom_range(3) == 0) ? 255 : 4);
        else if (pick < 65)
            send_item(KIND_ALLOC, 8'h00, 1'b1, 1'($urandom), 8'($urandom), 16'($urandom));
        else if (pick < 80)
            send_item(KIND_DELETE, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                      ($urandom_range(3) == 0) ? 16'($urandom)
                                               : (ID_BASE | 16'($urandom_range(0, 15))));
        else if (pick < 97)
            send_item(KIND_READ, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15)));
        else
            send_item(2'd3, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                      16'($urandom));
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_kind            = KIND_ALLOC;
        i_name_char       = 8'h00;
        i_name_end        = 1'b0;
        i_check_duplicate = 1'b0;
        i_skip_value      = 8'h00;
        i_name_id         = 16'h0000;
        i_stall           = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_off_cycles   = 0;
        quiet_cycles      = 0;
        items_sent        = 0;
        results_seen      = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(KIND_ALLOC, 8'h41, 1'b1, 1'b0, 8'h00, 16'h0000);
        send_item(KIND_ALLOC, 8'h41, 1'b1, 1'b1, 8'h00, 16'h0000);
        send_item(KIND_ALLOC, 8'h41, 1'b1, 1'b0, 8'hFF, 16'hFFFF);
        send_name(40, 1'b1, 255);
        send_item(KIND_READ, 8'h00, 1'b0, 1'b0, 8'h00, 16'h7802);
        send_item(KIND_ALLOC, 8'h42, 1'b0, 1'b0, 8'h00, 16'h0000);
        send_item(KIND_ALLOC, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
        send_item(KIND_ALLOC, 8'h43, 1'b1, 1'b1, 8'h00, 16'h0000);
        send_item(KIND_ALLOC, 8'h00, 1'b1, 1'b1, 8'h80, 16'h0000);
        send_item(KIND_DELETE, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0001);
        send_item(KIND_DELETE, 8'h00, 1'b0, 1'b0, 8'h00, 16'hFFFF);
        send_item(KIND_DELETE, 8'h00, 1'b0, 1'b0, 8'h00, 16'h7801);
        send_item(KIND_ALLOC, 8'h78, 1'b0, 1'b1, 8'h00, 16'h0000);
        send_item(KIND_READ, 8'h00, 1'b0, 1'b0, 8'h00, 16'h7800);
        send_item(KIND_DELETE, 8'h00, 1'b0, 1'b0, 8'h00, 16'h79FF);
        send_item(2'd3, 8'hFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF);
        send_item(KIND_ALLOC, 8'h79, 1'b1, 1'b1, 8'h01, 16'h0000);
        send_item(KIND_READ, 8'h00, 1'b0, 1'b0, 8'h00, 16'hFFFF);
        send_item(KIND_READ, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0003);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 85 : 6) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 85 : 6) : 0;
            for (int n = 0; n < 8; n++) random_item();
            wait_drained();
        end

        // A long receiver hold-off while reads keep coming fills the block up.
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 600;
        for (int n = 0; n < 12; n++)
            send_item(KIND_READ, 8'h00, 1'b0, 1'b0, 8'h00, 16'($urandom_range(0, 7)));
        wait_drained();

        recv_stall_pct = 20;
        send_idle_pct  = 20;
        for (int n = 0; n < 12; n++) random_item();
        wait_drained();

        $display("Sent %0d items and checked %0d results over idle, stall and hold-off phases,",
                 items_sent, results_seen);
        $display("including duplicates, long and empty names, reads and bad delete ids.");
        if (fail_count == 0 && answers_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### unique_name_table_allocator_unit.f
sv/untal_pkg.sv
sv/untal_ctrl.sv
sv/untal_dp.sv
sv/unique_name_table_allocator_unit.sv
tb/untal_checker.sv
tb/testbench.sv
